// ===== rtl/iffd_pkg.sv =====
// Shared constants and types for the id-synchronized fixed-frame deframer.
// No dependencies; imported by iffd_idset and id_synced_fixed_frame_deframer.
package iffd_pkg;

  // Frame geometry
  localparam int FRAME_LEN    = 25;
  localparam int IDX_W        = $clog2(FRAME_LEN);
  localparam int ID_W         = 8;
  localparam int BYTE_W       = 8;
  localparam int BYTE_INDEX_W = 5;

  // Id set configuration
  localparam int ID_WORDS   = 4;
  localparam int WORD_W     = 64;
  localparam int WORD_SEL_W = $clog2(ID_WORDS);
  localparam int BIT_SEL_W  = $clog2(WORD_W);
  localparam int CFG_IDX_W  = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ID_SET_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SET_WORD3 = 3'd3;

  // Packed output tdata width: fields rounded up to whole bytes
  localparam int OUT_FIELDS_W = ID_W + BYTE_INDEX_W + BYTE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic                    we;
    logic [CFG_IDX_W-1:0]    index;
    logic [WORD_W-1:0]       wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [ID_W-1:0]         device_id;
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]       data_byte;
    logic                    frame_end;
  } result_t;

endpackage

// ===== rtl/iffd_idset.sv =====
// Known device id set: four 64-bit bitmap registers and the membership lookup.
// Depends on iffd_pkg.
module iffd_idset (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iffd_pkg::cfg_wr_t     cfg_wr,
  input  logic [iffd_pkg::ID_W-1:0] lookup_id,
  output logic                  id_known
);
  import iffd_pkg::*;

  logic [ID_WORDS-1:0][WORD_W-1:0] id_set_r;
  logic [WORD_SEL_W-1:0]           word_sel;
  logic [BIT_SEL_W-1:0]            bit_sel;

  // Writes beyond the last word are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_set_r <= '0;
    end else if (cfg_wr.we && (cfg_wr.index <= REG_ID_SET_WORD3)) begin
      id_set_r[cfg_wr.index[WORD_SEL_W-1:0]] <= cfg_wr.wdata;
    end
  end

  assign word_sel = lookup_id[ID_W-1 -: WORD_SEL_W];
  assign bit_sel  = lookup_id[BIT_SEL_W-1:0];
  assign id_known = id_set_r[word_sel][bit_sel];

endmodule

// ===== rtl/id_synced_fixed_frame_deframer.sv =====
// Top level of the id-synchronized fixed-frame deframer: hunt, collect and output buffering.
// Depends on iffd_pkg and iffd_idset.
//
// The block takes one received byte per transfer and hunts for a frame start: a zero
// byte directly followed by a byte whose id bit is set in the 256-bit known-id set
// (cfg registers 0 to 3, bit b of word w marks id 64*w+b). From the id on, every byte up
// to index FRAME_LEN-1 (24) goes out as one result transfer tagged with the device id and
// its index; the final byte carries out_tlast. Bytes while hunting give no result, and
// bytes inside a frame never count as the zero of a new start. Each byte lands in the
// input register on its transfer edge, and its result is then registered in the output
// register (or in the skid while the output is held). One byte is taken every cycle as
// long as the output side keeps up, and a two-entry result buffer (output register plus
// skid) holds results while out_tready is low. Write the id set only while no transfer
// is in flight.
module id_synced_fixed_frame_deframer (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [iffd_pkg::OUT_DATA_W-1:0]   out_tdata,  // [7:0] device_id,
                                                        // [12:8] byte_index,
                                                        // [20:13] data_byte, rest zero
  output logic                              out_tlast,  // frame_end
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [iffd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iffd_pkg::WORD_W-1:0]       cfg_wdata
);
  import iffd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] FIRST_COLLECT_IDX = IDX_W'(2);
  localparam bit               START_IS_LAST = (FRAME_LEN - 1) <= 1;

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_go;

  // Frame tracking state
  logic              prev_zero_r, prev_zero_nxt;
  logic              collecting_r, collecting_nxt;
  logic [IDX_W-1:0]  next_index_r, next_index_nxt;
  logic [ID_W-1:0]   frame_dev_r, frame_dev_nxt;

  // Result path
  logic              res_valid;
  result_t           res;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  result_t           skid_r, skid_nxt;
  logic              out_fire;

  logic              id_known;
  logic              is_last;
  logic [7:0]        idx_ext;
  cfg_wr_t           cfg_wr;

  assign cfg_wr = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

  iffd_idset u_idset (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .lookup_id (s1_byte_r),
    .id_known  (id_known)
  );

  // Take a byte whenever the skid is free; the input stage always drains then
  assign in_tready = !skid_valid_r;
  assign s1_go     = s1_valid_r && !skid_valid_r;
  assign out_fire  = out_valid_r && out_tready;

  always_comb begin
    s1_valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Hunt / collect decision for the byte in the input register
  assign is_last = next_index_r >= LAST_IDX;
  assign idx_ext = 8'(next_index_r);

  always_comb begin
    prev_zero_nxt  = prev_zero_r;
    collecting_nxt = collecting_r;
    next_index_nxt = next_index_r;
    frame_dev_nxt  = frame_dev_r;
    res_valid      = 1'b0;
    res            = '{device_id: frame_dev_r, byte_index: idx_ext[BYTE_INDEX_W-1:0],
                       data_byte: s1_byte_r, frame_end: is_last};
    if (s1_go) begin
      priority if (collecting_r) begin
        res_valid     = 1'b1;
        prev_zero_nxt = 1'b0;
        if (is_last) begin
          collecting_nxt = 1'b0;
          next_index_nxt = '0;
        end else begin
          next_index_nxt = next_index_r + IDX_W'(1);
        end
      end else if (prev_zero_r && id_known) begin
        // Frame start: the id itself is byte 1
        res_valid      = 1'b1;
        res            = '{device_id: s1_byte_r, byte_index: BYTE_INDEX_W'(1),
                           data_byte: s1_byte_r, frame_end: START_IS_LAST};
        frame_dev_nxt  = s1_byte_r;
        prev_zero_nxt  = 1'b0;
        collecting_nxt = !START_IS_LAST;
        next_index_nxt = START_IS_LAST ? '0 : FIRST_COLLECT_IDX;
      end else begin
        prev_zero_nxt = (s1_byte_r == '0);
      end
    end
  end

  // Output register with skid: a new result lands in the skid only when the
  // output register is full and not being drained this cycle
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_fire) begin
      out_valid_nxt  = skid_valid_r;
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end else begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      prev_zero_r  <= 1'b0;
      collecting_r <= 1'b0;
      next_index_r <= '0;
      frame_dev_r  <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      prev_zero_r  <= prev_zero_nxt;
      collecting_r <= collecting_nxt;
      next_index_r <= next_index_nxt;
      frame_dev_r  <= frame_dev_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                       out_r.data_byte, out_r.byte_index, out_r.device_id};
  assign out_tlast  = out_r.frame_end;

  // The skid only ever fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  // While collecting, the next index stays inside the frame
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (next_index_r >= FIRST_COLLECT_IDX) && (next_index_r <= LAST_IDX))
    else $error("collect index out of frame range");

  // A final byte processed ends collection
  a_end_stops_collect: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && collecting_r && is_last) |=> !collecting_r && (next_index_r == '0))
    else $error("collection continued past the frame's final byte");

  // Hunting never emits unless a start is seen
  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !collecting_r && !prev_zero_r) |-> !res_valid)
    else $error("result produced while hunting without a start");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for id_synced_fixed_frame_deframer.
// Uses iffd_pkg for widths, register indexes and the result struct; needs only the RTL.
// A scoreboard class predicts each frame byte from the accepted rx bytes and checks it.
`timescale 1ns / 100ps

module testbench;
  import iffd_pkg::*;

  // Bytes that follow the id inside one frame
  localparam int FRAME_TAIL   = FRAME_LEN - 2;
  // Slack after the last expected result before touching the id set
  localparam int SETTLE       = 6;
  localparam int REG_SLOTS    = 2 ** CFG_IDX_W;
  localparam int PHASE_BYTES  = 360;
  localparam longint RUN_LIMIT_NS = 64'd16_000_000;

  // Scoreboard: keeps its own copy of the hunt/collect state and the id set, turns
  // every accepted rx byte into the frame byte it should produce (if any), and checks
  // result transfers in order against that list.
  class frame_scoreboard;
    logic [WORD_W-1:0] id_words [ID_WORDS];
    bit                prev_zero  = 1'b0;
    bit                collecting = 1'b0;
    logic [7:0]        next_idx   = '0;
    logic [ID_W-1:0]   frame_dev  = '0;
    result_t           bytes_due [$];
    int                fault_count = 0;

    function new();
      foreach (id_words[i]) id_words[i] = '0;
    endfunction

    // Indexes past the last id word are ignored by the block
    function void write_reg(int idx, logic [WORD_W-1:0] val);
      if (idx <= REG_ID_SET_WORD3) id_words[idx] = val;
    endfunction

    function bit is_known(logic [ID_W-1:0] id);
      return id_words[id[ID_W-1:BIT_SEL_W]][id[BIT_SEL_W-1:0]];
    endfunction

    // Any id of the current set, starting the search at a random point; -1 if empty
    function int any_known_id();
      int start;
      start = $urandom_range(0, 255);
      for (int i = 0; i < 256; i++) begin
        if (is_known(8'((start + i) % 256))) return (start + i) % 256;
      end
      return -1;
    endfunction

    function void take_rx_byte(logic [7:0] rx);
      result_t r;
      if (collecting) begin
        r.device_id  = frame_dev;
        r.byte_index = next_idx[BYTE_INDEX_W-1:0];
        r.data_byte  = rx;
        r.frame_end  = (int'(next_idx) >= FRAME_LEN - 1);
        bytes_due = {bytes_due, r};
        if (r.frame_end) begin
          collecting = 1'b0;
          next_idx   = '0;
        end else begin
          next_idx = next_idx + 8'd1;
        end
        // frame bytes never serve as the zero of the next start
        prev_zero = 1'b0;
      end else if (prev_zero && is_known(rx)) begin
        frame_dev    = rx;
        r.device_id  = rx;
        r.byte_index = BYTE_INDEX_W'(1);
        r.data_byte  = rx;
        r.frame_end  = (1 >= FRAME_LEN - 1);
        bytes_due = {bytes_due, r};
        prev_zero = 1'b0;
        if (r.frame_end) begin
          next_idx = '0;
        end else begin
          collecting = 1'b1;
          next_idx   = 8'd2;
        end
      end else begin
        prev_zero = (rx == 8'h00);
      end
    endfunction

    function void check_frame_byte(logic [OUT_DATA_W-1:0] data, logic tlast);
      result_t got;
      result_t want;
      got.device_id  = data[ID_W-1:0];
      got.byte_index = data[ID_W +: BYTE_INDEX_W];
      got.data_byte  = data[ID_W + BYTE_INDEX_W +: BYTE_W];
      got.frame_end  = tlast;
      if (bytes_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected frame byte dev %0d idx %0d data %02h end %0b",
                   $realtime, got.device_id, got.byte_index, got.data_byte, got.frame_end);
        return;
      end
      want = bytes_due.pop_front();
      if (got.device_id !== want.device_id || got.byte_index !== want.byte_index ||
          got.data_byte !== want.data_byte || got.frame_end !== want.frame_end) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: frame byte mismatch: expected dev %0d idx %0d data %02h end %0b, %s",
                   $realtime, want.device_id, want.byte_index, want.data_byte,
                   want.frame_end,
                   $sformatf("got dev %0d idx %0d data %02h end %0b", got.device_id,
                             got.byte_index, got.data_byte, got.frame_end));
      end
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction

    // Leftover expectations count as failures too
    function int failures();
      return fault_count + bytes_due.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [7:0]              in_tdata;    // [7:0] rx_byte
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;   // [7:0] device_id, [12:8] byte_index,
                                        // [20:13] data_byte, rest zero
  logic                    out_tlast;   // frame_end
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [WORD_W-1:0]       cfg_wdata;

  frame_scoreboard sb;
  bit              in_steady  = 1'b0;   // no gaps on the input side while set
  bit              out_steady = 1'b0;   // no stalls on the result side while set
  int              rx_sent    = 0;

  id_synced_fixed_frame_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random payload with extra weight on the zero and all-ones values
  function automatic logic [7:0] rand_rx_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Switch between stretches with random idling and stretches without any
  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // Result side: hold tready low for random stretches
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = out_steady ? 0 : pick_gap();
      end
    end
  end

  // Check every result transfer; values are those from before the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_frame_byte(out_tdata, out_tlast);
  end

  // Offer one rx byte after an optional gap and return at the edge of its transfer.
  // Keep tvalid high across back-to-back bytes so it gets one assignment per step.
  task automatic send_rx(input logic [7:0] rx);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_rx_byte(rx);
    rx_sent++;
  endtask

  // Drop tvalid and wait until every expected frame byte is out, then let the
  // pipeline settle so a last hunting byte cannot see a new id set.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four id words; optionally also hit the unused indexes with junk
  task automatic program_id_set(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                                input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                                input bit hit_unused, input bit junk_ones);
    logic [WORD_W-1:0] words [ID_WORDS];
    logic [WORD_W-1:0] junk;
    words = '{w0, w1, w2, w3};
    for (int idx = REG_ID_SET_WORD0; idx <= REG_ID_SET_WORD3; idx++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(idx);
      cfg_wdata <= words[idx];
      @(posedge clk);
      sb.write_reg(idx, words[idx]);
    end
    if (hit_unused) begin
      for (int idx = REG_ID_SET_WORD3 + 1; idx < REG_SLOTS; idx++) begin
        junk = junk_ones ? '1 : {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_wdata <= junk;
        @(posedge clk);
        sb.write_reg(idx, junk);
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: mostly well-formed frames (zero, known id, random tail),
  // the rest broken starts and plain noise.
  task automatic random_traffic(input int budget);
    int stop_at;
    int pick;
    int id;
    stop_at = rx_sent + budget;
    while (rx_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      id   = sb.any_known_id();
      if (pick < 70 && id >= 0) begin
        repeat ($urandom_range(1, 3)) send_rx(8'h00);
        send_rx(8'(id));
        repeat (FRAME_TAIL) send_rx(rand_rx_byte());
      end else if (pick < 82) begin
        // zero followed by whatever: usually an unknown id
        send_rx(8'h00);
        send_rx(rand_rx_byte());
      end else begin
        repeat ($urandom_range(1, 6)) send_rx(rand_rx_byte());
      end
    end
    drain();
  endtask

  initial begin
    // id 0 and id 5 known: a frame from id 0, a non-start on a stray id 5,
    // and an unknown id right after a zero
    logic [7:0] directed [$];
    directed = '{8'h05, 8'h00, 8'hA0, 8'h00, 8'h00,
                 8'hFF, 8'h00, 8'h00, 8'h05, 8'h80, 8'h01, 8'h7F, 8'hFE,
                 8'h55, 8'hAA, 8'h00, 8'hFF, 8'h10, 8'h20, 8'h40, 8'h08,
                 8'h04, 8'h02, 8'hF0, 8'h0F, 8'hC3, 8'h3C, 8'h00,
                 8'h05};
    sb = new();

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty id set, unused indexes all ones: nothing may ever start
    program_id_set('0, '0, '0, '0, 1'b1, 1'b1);
    random_traffic(120);

    // Directed: zero id, zeros inside a frame, the frame's last zero before an id
    program_id_set(64'h21, '0, '0, '0, 1'b0, 1'b0);
    foreach (directed[i]) send_rx(directed[i]);
    drain();

    // Every id known
    program_id_set('1, '1, '1, '1, 1'b0, 1'b0);
    random_traffic(PHASE_BYTES);

    // Random set, random junk on the unused indexes
    program_id_set({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b0);
    random_traffic(PHASE_BYTES);

    // Only the top id
    program_id_set('0, '0, '0, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
    random_traffic(PHASE_BYTES);

    // Sparse set
    program_id_set({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                   1'b0, 1'b0);
    random_traffic(PHASE_BYTES);

    // Random set with id 0 forced in, so "0 0" starts show up often
    program_id_set({$urandom, $urandom} | 64'h1, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    random_traffic(PHASE_BYTES);

    // Allow any stray late result to show up before the verdict
    repeat (16) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/iffd_pkg.sv
rtl/iffd_idset.sv
rtl/id_synced_fixed_frame_deframer.sv
sim/testbench.sv
